@@ rtl/core/qnl_pkg.sv @@
package qnl_pkg;

    localparam int LANES      = 4;
    localparam int MAG_W      = 31;
    localparam int SQ_W       = 63;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = 33;
    localparam int ROOT_STEPS = 32;
    localparam int PROD_W     = 32;
    localparam int DOT_W      = 34;
    localparam logic [15:0] K_ONE = 16'd32768;

    typedef logic [MAG_W-1:0] t_mag;

    typedef struct packed {
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] a_w;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] b_w;
        logic        [15:0] k_weight;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] r_x;
        logic signed [15:0] r_y;
        logic signed [15:0] r_z;
        logic signed [15:0] r_w;
        logic               zero_norm;
    } t_out_beat;

    typedef struct packed {
        logic                  zero;
        logic [LANES-1:0]      neg;
        t_mag [LANES-1:0]      mag;
    } t_root_side;

    typedef struct packed {
        logic             zero;
        logic [LANES-1:0] neg;
    } t_div_side;

endpackage

@@ rtl/core/qnl_stream_if.sv @@
interface qnl_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/qnl_blend.sv @@
module qnl_blend
    import qnl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_in_beat   i_beat,
    output logic       o_valid,
    output logic [SQ_W-1:0] o_sq,
    output t_root_side o_side
);

    logic signed [15:0] w_a [LANES];
    logic signed [15:0] w_b [LANES];
    logic [15:0] w_k;
    logic [15:0] w_k0;

    logic [4:0] r_valid;

    logic signed [PROD_W-1:0] r_ab  [LANES];
    logic signed [PROD_W-1:0] r_ak0 [LANES];
    logic signed [PROD_W-1:0] r_bk  [LANES];
    logic signed [PROD_W-1:0] r_ak0_2 [LANES];
    logic signed [PROD_W-1:0] r_bk_2  [LANES];
    logic r_pos;
    t_mag r_mag [LANES];
    t_mag r_mag_4 [LANES];
    logic [LANES-1:0] r_neg;
    logic [LANES-1:0] r_neg_4;
    logic [LANES-1:0] r_neg_5;
    logic [2*MAG_W-1:0] r_sqr [LANES];
    logic r_zero_4;
    logic r_zero_5;
    t_mag r_mag_5 [LANES];
    logic [SQ_W-1:0] r_sum;

    logic signed [DOT_W-1:0] w_dot;
    logic signed [PROD_W-1:0] w_m [LANES];

    always_comb begin
        w_a[0] = i_beat.a_x;
        w_a[1] = i_beat.a_y;
        w_a[2] = i_beat.a_z;
        w_a[3] = i_beat.a_w;
        w_b[0] = i_beat.b_x;
        w_b[1] = i_beat.b_y;
        w_b[2] = i_beat.b_z;
        w_b[3] = i_beat.b_w;
        w_k    = (i_beat.k_weight > K_ONE) ? K_ONE : i_beat.k_weight;
        w_k0   = K_ONE - w_k;
    end

    always_comb begin
        w_dot = '0;
        for (int i = 0; i < LANES; i++) begin
            w_dot = w_dot + DOT_W'(r_ab[i]);
        end
        for (int i = 0; i < LANES; i++) begin
            w_m[i] = r_pos ? (r_ak0_2[i] + r_bk_2[i]) : (r_ak0_2[i] - r_bk_2[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < LANES; i++) begin
                r_ab[i]  <= PROD_W'(w_a[i]) * PROD_W'(w_b[i]);
                r_ak0[i] <= PROD_W'($signed(33'(w_a[i])) * $signed({17'd0, w_k0}));
                r_bk[i]  <= PROD_W'($signed(33'(w_b[i])) * $signed({17'd0, w_k}));
            end
            r_pos <= (w_dot > 0);
            for (int i = 0; i < LANES; i++) begin
                r_ak0_2[i] <= r_ak0[i];
                r_bk_2[i]  <= r_bk[i];
                r_neg[i]   <= w_m[i][PROD_W-1];
                r_mag[i]   <= MAG_W'(w_m[i][PROD_W-1] ? -w_m[i] : w_m[i]);
                r_sqr[i]   <= (2*MAG_W)'(r_mag[i]) * (2*MAG_W)'(r_mag[i]);
                r_mag_4[i] <= r_mag[i];
                r_mag_5[i] <= r_mag_4[i];
            end
            r_neg_4  <= r_neg;
            r_neg_5  <= r_neg_4;
            r_zero_4 <= (r_mag[0] == '0) && (r_mag[1] == '0)
                        && (r_mag[2] == '0) && (r_mag[3] == '0);
            r_zero_5 <= r_zero_4;
            r_sum    <= SQ_W'(r_sqr[0]) + SQ_W'(r_sqr[1])
                        + SQ_W'(r_sqr[2]) + SQ_W'(r_sqr[3]);
        end
    end

    always_comb begin
        o_valid     = r_valid[4];
        o_sq        = r_sum;
        o_side.zero = r_zero_5;
        o_side.neg  = r_neg_5;
        for (int i = 0; i < LANES; i++) begin
            o_side.mag[i] = r_mag_5[i];
        end
    end

endmodule

@@ rtl/core/qnl_root_cell.sv @@
module qnl_root_cell
    import qnl_pkg::*;
#(
    parameter int  K      = 0,
    parameter type T_SIDE = logic
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [SQ_W-1:0] i_rem,
    input  logic [SQ_W-1:0] i_root,
    input  T_SIDE           i_side,
    output logic            o_valid,
    output logic [SQ_W-1:0] o_rem,
    output logic [SQ_W-1:0] o_root,
    output T_SIDE           o_side
);

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2*K);

    logic [SQ_W-1:0] w_trial;
    logic [SQ_W-1:0] n_rem;
    logic [SQ_W-1:0] n_root;
    logic            r_valid;
    logic [SQ_W-1:0] r_rem;
    logic [SQ_W-1:0] r_root;
    T_SIDE           r_side;

    always_comb begin
        w_trial = i_root + BIT;
        if (i_rem >= w_trial) begin
            n_rem  = i_rem - w_trial;
            n_root = (i_root >> 1) + BIT;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

@@ rtl/core/qnl_div_cell.sv @@
module qnl_div_cell
    import qnl_pkg::*;
#(
    parameter int QW   = 16,
    parameter int STEP = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [REM_W-1:0]  i_rem [LANES],
    input  logic [QW-1:0]     i_quo [LANES],
    input  logic [ROOT_W-1:0] i_div,
    input  t_div_side         i_side,
    output logic              o_valid,
    output logic [REM_W-1:0]  o_rem [LANES],
    output logic [QW-1:0]     o_quo [LANES],
    output logic [ROOT_W-1:0] o_div,
    output t_div_side         o_side
);

    localparam bit FIRST = (STEP == QW-1);

    logic [REM_W-1:0]  w_t   [LANES];
    logic [REM_W-1:0]  n_rem [LANES];
    logic [QW-1:0]     n_quo [LANES];
    logic              r_valid;
    logic [REM_W-1:0]  r_rem [LANES];
    logic [QW-1:0]     r_quo [LANES];
    logic [ROOT_W-1:0] r_div;
    t_div_side         r_side;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_t[l]   = FIRST ? i_rem[l] : (i_rem[l] << 1);
            n_quo[l] = i_quo[l];
            if (w_t[l] >= REM_W'(i_div)) begin
                n_rem[l]       = w_t[l] - REM_W'(i_div);
                n_quo[l][STEP] = 1'b1;
            end else begin
                n_rem[l] = w_t[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_div  <= i_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

@@ rtl/core/quaternion_nlerp_core.sv @@
// Pipeline from input beat to output beat: 5 blend stages, 32 square-root cells,
// FRACTION_BITS + 2 divider cells, 1 output stage.
// Throughput: one beat per cycle; the whole pipeline holds while the output beat waits.
// Reset clears every valid bit in the chain, including the output valid; data regs keep values.
module quaternion_nlerp_core
    import qnl_pkg::*;
#(
    parameter int FRACTION_BITS = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qnl_stream_if.sink    i_in,
    qnl_stream_if.source  o_out
);

    localparam int QW      = FRACTION_BITS + 2;
    localparam int ONE     = 1 << FRACTION_BITS;
    localparam int POS_LIM = (ONE > 32767) ? 32767 : ONE;
    localparam int NEG_LIM = (ONE > 32768) ? 32768 : ONE;

    logic w_en;
    logic r_out_valid;
    t_out_beat r_out_data;
    t_out_beat n_out_data;

    logic            w_blend_valid;
    logic [SQ_W-1:0] w_blend_sq;
    t_root_side      w_blend_side;

    logic            w_rvalid [ROOT_STEPS+1];
    logic [SQ_W-1:0] w_rrem   [ROOT_STEPS+1];
    logic [SQ_W-1:0] w_rroot  [ROOT_STEPS+1];
    t_root_side      w_rside  [ROOT_STEPS+1];

    logic              w_dvalid [QW+1];
    logic [REM_W-1:0]  w_drem   [QW+1][LANES];
    logic [QW-1:0]     w_dquo   [QW+1][LANES];
    logic [ROOT_W-1:0] w_ddiv   [QW+1];
    t_div_side         w_dside  [QW+1];

    logic [QW:0] w_round [LANES];
    logic [16:0] w_clip  [LANES];
    logic [15:0] w_res   [LANES];

    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    qnl_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_beat  (i_in.data),
        .o_valid (w_blend_valid),
        .o_sq    (w_blend_sq),
        .o_side  (w_blend_side)
    );

    assign w_rvalid[0] = w_blend_valid;
    assign w_rrem[0]   = w_blend_sq;
    assign w_rroot[0]  = '0;
    assign w_rside[0]  = w_blend_side;

    for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
        qnl_root_cell #(
            .K      (ROOT_STEPS - 1 - g),
            .T_SIDE (t_root_side)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_rvalid[g]),
            .i_rem   (w_rrem[g]),
            .i_root  (w_rroot[g]),
            .i_side  (w_rside[g]),
            .o_valid (w_rvalid[g+1]),
            .o_rem   (w_rrem[g+1]),
            .o_root  (w_rroot[g+1]),
            .o_side  (w_rside[g+1])
        );
    end

    always_comb begin
        w_dvalid[0]   = w_rvalid[ROOT_STEPS];
        w_ddiv[0]     = w_rroot[ROOT_STEPS][ROOT_W-1:0];
        w_dside[0]    = '{zero: w_rside[ROOT_STEPS].zero, neg: w_rside[ROOT_STEPS].neg};
        for (int l = 0; l < LANES; l++) begin
            w_drem[0][l] = REM_W'(w_rside[ROOT_STEPS].mag[l]);
            w_dquo[0][l] = '0;
        end
    end

    for (genvar g = 0; g < QW; g++) begin : g_div
        qnl_div_cell #(
            .QW   (QW),
            .STEP (QW - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dvalid[g]),
            .i_rem   (w_drem[g]),
            .i_quo   (w_dquo[g]),
            .i_div   (w_ddiv[g]),
            .i_side  (w_dside[g]),
            .o_valid (w_dvalid[g+1]),
            .o_rem   (w_drem[g+1]),
            .o_quo   (w_dquo[g+1]),
            .o_div   (w_ddiv[g+1]),
            .o_side  (w_dside[g+1])
        );
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_round[l] = ({1'b0, w_dquo[QW][l]} + (QW+1)'(1)) >> 1;
            if (w_dside[QW].neg[l]) begin
                w_clip[l] = (w_round[l] > (QW+1)'(NEG_LIM)) ? 17'(NEG_LIM)
                                                             : 17'(w_round[l]);
                w_res[l]  = 16'(-w_clip[l]);
            end else begin
                w_clip[l] = (w_round[l] > (QW+1)'(POS_LIM)) ? 17'(POS_LIM)
                                                             : 17'(w_round[l]);
                w_res[l]  = 16'(w_clip[l]);
            end
            if (w_dside[QW].zero) begin
                w_res[l] = '0;
            end
        end
        n_out_data.r_x       = w_res[0];
        n_out_data.r_y       = w_res[1];
        n_out_data.r_z       = w_res[2];
        n_out_data.r_w       = w_res[3];
        n_out_data.zero_norm = w_dside[QW].zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dvalid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule

@@ tb/quaternion_nlerp_core_tb.sv @@
module quaternion_nlerp_core_tb;
    import qnl_pkg::*;

    localparam int FB       = 14;
    localparam int LATENCY  = FB + 40;
    localparam int N_RANDOM = 2000;
    localparam longint CYCLE_LIMIT = 2000000;

    class nlerp_scoreboard;
        t_out_beat pending[$];
        int        errors;

        function automatic logic [63:0] root_floor(logic [63:0] q);
            logic [63:0] res;
            logic [63:0] bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > q) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (q >= res + bitv) begin
                    q   = q - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function automatic t_out_beat blend(t_in_beat x);
            longint    a[4], b[4], m[4];
            longint    dot, k, k0, k1, s, one, plim, nlim;
            logic [63:0] q, n, mag, r;
            t_out_beat o;
            a = '{x.a_x, x.a_y, x.a_z, x.a_w};
            b = '{x.b_x, x.b_y, x.b_z, x.b_w};
            dot = 0;
            for (int i = 0; i < 4; i++) dot += a[i] * b[i];
            k  = x.k_weight > 32768 ? 32768 : longint'(x.k_weight);
            k0 = 32768 - k;
            k1 = dot > 0 ? k : -k;
            q  = 0;
            for (int i = 0; i < 4; i++) begin
                m[i] = a[i] * k0 + b[i] * k1;
                mag  = m[i] < 0 ? -m[i] : m[i];
                q    = q + mag * mag;
            end
            o = '0;
            if (q == 0) begin
                o.zero_norm = 1'b1;
                return o;
            end
            n    = root_floor(q);
            one  = 64'd1 << FB;
            plim = one > 32767 ? 32767 : one;
            nlim = one > 32768 ? 32768 : one;
            for (int i = 0; i < 4; i++) begin
                mag = m[i] < 0 ? -m[i] : m[i];
                r   = (2 * mag * one + n) / (2 * n);
                if (m[i] < 0) s = r > nlim ? -nlim : -longint'(r);
                else          s = r > plim ? plim : longint'(r);
                case (i)
                    0: o.r_x = s[15:0];
                    1: o.r_y = s[15:0];
                    2: o.r_z = s[15:0];
                    default: o.r_w = s[15:0];
                endcase
            end
            return o;
        endfunction

        function void note_input(t_in_beat x);
            pending.push_back(blend(x));
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat e;
            if (pending.size() == 0) begin
                $error("unexpected output beat %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.r_x !== e.r_x) begin
                $error("r_x expected %0d actual %0d", e.r_x, got.r_x); errors++;
            end
            if (got.r_y !== e.r_y) begin
                $error("r_y expected %0d actual %0d", e.r_y, got.r_y); errors++;
            end
            if (got.r_z !== e.r_z) begin
                $error("r_z expected %0d actual %0d", e.r_z, got.r_z); errors++;
            end
            if (got.r_w !== e.r_w) begin
                $error("r_w expected %0d actual %0d", e.r_w, got.r_w); errors++;
            end
            if (got.zero_norm !== e.zero_norm) begin
                $error("zero_norm expected %0d actual %0d", e.zero_norm, got.zero_norm);
                errors++;
            end
        endfunction
    endclass

    logic   i_clk;
    logic   i_rst_n;
    longint cycles;
    nlerp_scoreboard sb;

    qnl_stream_if #(.T(t_in_beat))  in_if ();
    qnl_stream_if #(.T(t_out_beat)) out_if ();

    quaternion_nlerp_core #(.FRACTION_BITS(FB)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 80);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
        return 0;
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h4000;
            3: return 16'hc000;
            4: return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_k();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic send_beat(t_in_beat x);
        int g;
        g = gap_len();
        if (g != 0) begin
            in_if.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= x;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_input(x);
        @(negedge i_clk);
    endtask

    task automatic idle_input();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_in_beat make_beat(logic [15:0] ax, ay, az, aw, bx, by, bz, bw, k);
        t_in_beat x;
        x = '{ax, ay, az, aw, bx, by, bz, bw, k};
        return x;
    endfunction

    initial begin
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        sb = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_beat(make_beat(16'h4000, 0, 0, 0, 16'h4000, 0, 0, 0, 16'd0));
        send_beat(make_beat(16'h4000, 0, 0, 0, 16'h4000, 0, 0, 0, 16'd32768));
        send_beat(make_beat(16'h4000, 0, 0, 0, 16'hc000, 0, 0, 0, 16'd16384));
        send_beat(make_beat(16'h4000, 0, 0, 0, 0, 16'h4000, 0, 0, 16'd16384));
        send_beat(make_beat(16'h4000, 0, 0, 0, 0, 16'h4000, 0, 0, 16'hffff));
        send_beat(make_beat(0, 0, 0, 0, 0, 0, 0, 0, 16'd12345));
        send_beat(make_beat(0, 0, 0, 0, 16'h1234, 0, 0, 0, 16'd0));
        send_beat(make_beat(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                            16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd16384));
        send_beat(make_beat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                            16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd16384));
        send_beat(make_beat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                            16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'd1));
        send_beat(make_beat(16'd1, 0, 0, 0, 0, 0, 0, 0, 16'd32767));
        send_beat(make_beat(16'd1, 16'd1, 0, 0, 0, 0, 0, 0, 16'd32767));
        send_beat(make_beat(16'hffff, 0, 0, 16'd1, 0, 0, 0, 0, 16'd0));
        send_beat(make_beat(16'h7fff, 0, 0, 0, 16'h7fff, 0, 0, 0, 16'h8001));

        idle_input();
        while (sb.pending.size() != 0) @(negedge i_clk);

        for (int i = 0; i < N_RANDOM; i++) begin
            send_beat(make_beat(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                                rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                                rand_k()));
            if (i == N_RANDOM / 2) begin
                idle_input();
                while (sb.pending.size() != 0) @(negedge i_clk);
            end
        end

        idle_input();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 20) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            g = gap_len();
            if (g != 0) begin
                out_if.ready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            repeat ($urandom_range(0, 30)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.data);
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule
